### hw/rtl/mlja_pkg.sv
// Shared types and constants for the min-load job assigner.
package mlja_pkg;

  localparam int unsigned LOAD_W     = 32;
  localparam int unsigned JOB_W      = 16;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned HEAP_IDX_W = 17;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned ROW_W      = 2 * LOAD_W;

  typedef struct packed {
    logic              valid;
    logic [LOAD_W-1:0] moving;
    logic [POS_W-1:0]  pos;
    logic [ROW_W-1:0]  prow;
  } tok_t;

  typedef struct packed {
    logic             we;
    logic             fin;
    logic [POS_W-1:0] row;
    logic [ROW_W-1:0] data;
  } wb_t;

  typedef struct packed {
    logic             active;
    logic [POS_W-1:0] row;
  } clr_t;

endpackage

### hw/rtl/mlja_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlja_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mlja_level_cell.sv
// One heap level: stores its loads in sibling pairs and steps the sift-down token.
module mlja_level_cell #(
  parameter int unsigned LEVEL    = 1,
  parameter int unsigned MACHINES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mlja_pkg::HEAP_IDX_W-1:0] count_i,
  input  mlja_pkg::clr_t                  clr_i,
  input  mlja_pkg::tok_t                  tok_i,
  output mlja_pkg::tok_t                  tok_o,
  input  mlja_pkg::wb_t                   wb_i,
  output mlja_pkg::wb_t                   wb_o
);
  import mlja_pkg::*;

  localparam int unsigned LvlSpan  = 2 ** LEVEL;
  localparam int unsigned Entries  = (LvlSpan < MACHINES - LvlSpan + 1) ?
                                     LvlSpan : (MACHINES - LvlSpan + 1);
  localparam int unsigned Rows     = (Entries + 1) / 2;
  localparam int unsigned AddrW    = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned IW       = HEAP_IDX_W + 1;

  function automatic logic [ROW_W-1:0] put_half(logic [ROW_W-1:0] row, logic half,
                                                logic [LOAD_W-1:0] val);
    logic [ROW_W-1:0] res;
    res = row;
    if (half) begin
      res[ROW_W-1:LOAD_W] = val;
    end else begin
      res[LOAD_W-1:0] = val;
    end
    return res;
  endfunction

  tok_t             tok_q, tok_d;
  tok_t             tok_o_q, tok_o_d;
  wb_t              wb_q, wb_d;
  logic [IW-1:0]    left_in, left_st, right_st, count_ext;
  logic             child_in, right_ok, pick_right;
  logic [LOAD_W-1:0] left_val, right_val, child_val;
  logic [ROW_W-1:0] rd_data;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  always_comb begin
    count_ext  = IW'(count_i);
    left_in    = IW'(LvlSpan - 1) + IW'({tok_i.pos, 1'b0});
    child_in   = left_in < count_ext;
    left_st    = IW'(LvlSpan - 1) + IW'({tok_q.pos, 1'b0});
    right_st   = left_st + IW'(1);
    right_ok   = right_st < count_ext;
    left_val   = rd_data[LOAD_W-1:0];
    right_val  = rd_data[ROW_W-1:LOAD_W];
    pick_right = right_ok && (right_val < left_val);
    child_val  = pick_right ? right_val : left_val;

    tok_d       = tok_i;
    tok_d.valid = tok_i.valid && child_in;
    tok_o_d     = '0;
    wb_d        = '0;

    if (tok_i.valid && !child_in) begin
      wb_d.we   = 1'b1;
      wb_d.fin  = 1'b1;
      wb_d.row  = tok_i.pos >> 1;
      wb_d.data = put_half(tok_i.prow, tok_i.pos[0], tok_i.moving);
    end else if (tok_q.valid) begin
      wb_d.we  = 1'b1;
      wb_d.row = tok_q.pos >> 1;
      if (tok_q.moving <= child_val) begin
        wb_d.fin  = 1'b1;
        wb_d.data = put_half(tok_q.prow, tok_q.pos[0], tok_q.moving);
      end else begin
        wb_d.data      = put_half(tok_q.prow, tok_q.pos[0], child_val);
        tok_o_d.valid  = 1'b1;
        tok_o_d.moving = tok_q.moving;
        tok_o_d.pos    = {tok_q.pos[POS_W-2:0], pick_right};
        tok_o_d.prow   = rd_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      tok_o_q <= '0;
      wb_q    <= '0;
    end else begin
      tok_q   <= tok_d;
      tok_o_q <= tok_o_d;
      wb_q    <= wb_d;
    end
  end

  always_comb begin
    if (clr_i.active) begin
      ram_we    = clr_i.row < POS_W'(Rows);
      ram_waddr = clr_i.row[AddrW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = wb_i.we;
      ram_waddr = wb_i.row[AddrW-1:0];
      ram_wdata = wb_i.data;
    end
  end

  mlja_ram #(
    .WIDTH(ROW_W),
    .DEPTH(Rows)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (tok_d.valid),
    .raddr_i(tok_i.pos[AddrW-1:0]),
    .rdata_o(rd_data)
  );

  assign tok_o = tok_o_q;
  assign wb_o  = wb_q;

endmodule

### hw/rtl/min_load_job_assigner_core.sv
// Top level of the min-load job assigner: root load, running maximum and level chain.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid_i/tready_o      tdata[15:0] job_time, tlast last_job
//   m_axis    out        m_axis_tvalid_o/tready_i      tdata[31:0] makespan
//   cfg       in         cfg_we_i                      cfg_wdata_i[10:0] machine_count
//
// A job holds the core in S_SIFT while its token descends the heap levels, until it stops
// on a compare or reaches a node without children; no new job is taken meanwhile. The
// level-to-level handoff of the sift token sets how long that takes.
// After reset and after each last job, a clearing pass zeroes every level RAM in
// parallel; no job is taken meanwhile.
// The makespan waits in an output register; a later last job holds until it is taken.
module min_load_job_assigner_core #(
  parameter int unsigned MACHINES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mlja_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [mlja_pkg::JOB_W-1:0]   s_axis_tdata_i,   // [15:0] job_time
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [mlja_pkg::LOAD_W-1:0]  m_axis_tdata_o    // [31:0] makespan
);
  import mlja_pkg::*;

  localparam int unsigned NLev   = $clog2(MACHINES + 1);
  localparam int unsigned ClrLen = (MACHINES + 3) / 4 + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SIFT,
    S_EMIT
  } state_e;

  state_e                state_q;
  logic [CFG_W-1:0]      cfg_q;
  logic [HEAP_IDX_W-1:0] count_q, count_d;
  logic [LOAD_W-1:0]     root_q, max_q, out_q;
  logic                  out_valid_q, last_q;
  logic [POS_W-1:0]      clr_cnt_q;
  tok_t                  tok1_q;
  clr_t                  clr;
  wb_t                   root_wb;
  logic                  fin_any;
  logic [LOAD_W:0]       sum;
  logic [LOAD_W-1:0]     load;
  logic                  accept;
  logic                  emit_go;

  always_comb begin
    priority if (cfg_q == '0) begin
      count_d = HEAP_IDX_W'(1);
    end else if (HEAP_IDX_W'(cfg_q) > HEAP_IDX_W'(MACHINES)) begin
      count_d = HEAP_IDX_W'(MACHINES);
    end else begin
      count_d = HEAP_IDX_W'(cfg_q);
    end
    sum    = {1'b0, root_q} + (LOAD_W + 1)'(s_axis_tdata_i);
    load   = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
    accept = s_axis_tvalid_i && s_axis_tready_o;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign emit_go         = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);
  assign clr.active      = (state_q == S_CLEAR);
  assign clr.row         = clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= CFG_W'(1);
      count_q <= HEAP_IDX_W'(1);
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      tok1_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      root_q      <= '0;
      max_q       <= '0;
      out_q       <= '0;
    end else begin
      tok1_q.valid <= accept;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          root_q    <= '0;
          max_q     <= '0;
          clr_cnt_q <= clr_cnt_q + POS_W'(1);
          if (clr_cnt_q == POS_W'(ClrLen - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            root_q        <= load;
            max_q         <= (load > max_q) ? load : max_q;
            last_q        <= s_axis_tlast_i;
            tok1_q.moving <= load;
            tok1_q.pos    <= '0;
            tok1_q.prow   <= '0;
            state_q       <= S_SIFT;
          end
        end
        S_SIFT: begin
          if (root_wb.we) begin
            root_q <= root_wb.data[LOAD_W-1:0];
          end
          if (fin_any) begin
            state_q <= last_q ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_q     <= max_q;
            clr_cnt_q <= '0;
            state_q   <= S_CLEAR;
          end
        end
        default: begin
          state_q <= S_CLEAR;
        end
      endcase
    end
  end

  generate
    if (NLev > 1) begin : g_chain
      tok_t             tok [1:NLev];
      wb_t              wb  [1:NLev];
      wb_t              wb_end;
      logic [NLev-1:1]  fin_vec;

      assign tok[1] = tok1_q;

      // a token leaving the deepest level lands on a node without children
      always_comb begin
        wb_end      = '0;
        wb_end.we   = tok[NLev].valid;
        wb_end.fin  = tok[NLev].valid;
        wb_end.row  = tok[NLev].pos >> 1;
        wb_end.data = tok[NLev].pos[0] ?
                      {tok[NLev].moving, tok[NLev].prow[LOAD_W-1:0]} :
                      {tok[NLev].prow[ROW_W-1:LOAD_W], tok[NLev].moving};
      end

      assign wb[NLev] = wb_end;

      for (genvar k = 1; k < NLev; k++) begin : g_lvl
        mlja_level_cell #(
          .LEVEL   (k),
          .MACHINES(MACHINES)
        ) u_cell (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .count_i(count_q),
          .clr_i  (clr),
          .tok_i  (tok[k]),
          .tok_o  (tok[k+1]),
          .wb_i   (wb[k+1]),
          .wb_o   (wb[k])
        );
        assign fin_vec[k] = wb[k].fin;
      end

      assign root_wb = wb[1];
      assign fin_any = (|fin_vec) || wb_end.fin;
    end else begin : g_single
      assign root_wb = '0;
      assign fin_any = tok1_q.valid;
    end
  endgenerate

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule
